// ===== rtl/kway_merge_group_edges_unit_defines.svh =====
`ifndef KWAY_MERGE_GROUP_EDGES_UNIT_DEFINES_SVH
`define KWAY_MERGE_GROUP_EDGES_UNIT_DEFINES_SVH

// same-cycle implication
`define KMG_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KMG_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/kmg_pkg.sv =====
`timescale 1ns / 1ps
package kmg_pkg;

	localparam int MAX_RUNS_DEF    = 64;
	localparam int VERTEX_BITS_DEF = 24;
	localparam int LABEL_BITS_DEF  = 16;
	localparam int RUN_BITS        = 6;
	localparam int CNT_BITS        = 32;

	typedef enum logic [1:0] {
		FN_LOAD   = 2'd0,
		FN_REFILL = 2'd1,
		FN_POP    = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_POP_RD,
		ST_POP_TOP,
		ST_SD_RD,
		ST_SD_CMP,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic vld;
		logic empty;
	} pop_ev_t;

	typedef struct packed {
		logic heap_empty;
		logic repeat_label;
		logic new_pair;
	} flags_t;

endpackage

// ===== rtl/kmg_heap_ram.sv =====
`timescale 1ns / 1ps
module kmg_heap_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 70
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== rtl/kmg_seq.sv =====
`timescale 1ns / 1ps
`include "kway_merge_group_edges_unit_defines.svh"
module kmg_seq
	import kmg_pkg::*;
#(
	parameter int MAX_RUNS    = MAX_RUNS_DEF,
	parameter int VERTEX_BITS = VERTEX_BITS_DEF,
	parameter int LABEL_BITS  = LABEL_BITS_DEF,
	localparam int EW = 2 * VERTEX_BITS + LABEL_BITS + RUN_BITS,
	localparam int IW = $clog2(MAX_RUNS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	output logic                          in_rdy,
	input  logic [1:0]                    in_func,
	input  logic [RUN_BITS-1:0]           in_run,
	input  logic [EW-RUN_BITS-1:0]        in_key,
	input  logic                          out_free,
	output logic                          deliver,
	output pop_ev_t                       ev,
	output logic                          ram_we,
	output logic [IW-1:0]                 ram_waddr,
	output logic [EW-1:0]                 ram_wdata,
	output logic [IW-1:0]                 ram_raddr_a,
	output logic [IW-1:0]                 ram_raddr_b,
	input  logic [EW-1:0]                 ram_rdata_a,
	input  logic [EW-1:0]                 ram_rdata_b
);

	localparam int CW = $clog2(MAX_RUNS + 1);
	localparam int LW = IW + 1;

	state_t              st_q, st_nxt;
	logic [CW-1:0]       cnt_q;
	logic [IW-1:0]       idx_q;
	logic [IW-1:0]       par_q;
	logic [LW-1:0]       lc_q;
	logic [EW-1:0]       x_q;
	logic                refill_q;
	logic [RUN_BITS-1:0] last_run_q;

	logic                accept;
	logic                ins_ok;
	logic [IW-1:0]       par;
	logic [LW-1:0]       lchild;
	logic                l_ok;
	logic                r_ok;
	logic                pick_b;
	logic [EW-1:0]       child;
	logic [IW-1:0]       cidx;
	logic [RUN_BITS-1:0] ins_run;

	assign accept  = in_vld && in_rdy;
	assign ins_ok  = cnt_q < CW'(MAX_RUNS);
	assign par     = (idx_q - 1'b1) >> 1;
	assign lchild  = {idx_q, 1'b1};
	assign l_ok    = lchild < LW'(cnt_q);
	assign r_ok    = ({1'b0, lc_q} + 1'b1) < (LW + 1)'(cnt_q);
	assign pick_b  = r_ok && (ram_rdata_b < ram_rdata_a);
	assign child   = pick_b ? ram_rdata_b : ram_rdata_a;
	assign cidx    = pick_b ? lc_q[IW-1:0] + 1'b1 : lc_q[IW-1:0];
	assign ins_run = (func_t'(in_func) == FN_REFILL) ? last_run_q : in_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_nxt;
		end
	end

	always_comb begin
		st_nxt      = st_q;
		in_rdy      = 1'b0;
		deliver     = 1'b0;
		ev          = '0;
		ram_we      = 1'b0;
		ram_waddr   = idx_q;
		ram_wdata   = x_q;
		ram_raddr_a = '0;
		ram_raddr_b = '0;
		unique case (st_q)
			ST_IDLE: begin
				in_rdy = 1'b1;
				if (in_vld) begin
					case (func_t'(in_func))
						FN_LOAD:   st_nxt = ins_ok ? ST_INS_RD : ST_IDLE;
						FN_REFILL: st_nxt = ins_ok ? ST_INS_RD : ST_POP_RD;
						FN_POP:    st_nxt = ST_POP_RD;
						default:   st_nxt = ST_IDLE;
					endcase
				end
			end
			ST_INS_RD: begin
				if (idx_q == '0) begin
					ram_we = 1'b1;
					st_nxt = refill_q ? ST_POP_RD : ST_IDLE;
				end else begin
					ram_raddr_a = par;
					st_nxt      = ST_INS_CMP;
				end
			end
			ST_INS_CMP: begin
				ram_we = 1'b1;
				if (x_q < ram_rdata_a) begin
					ram_wdata = ram_rdata_a;
					st_nxt    = ST_INS_RD;
				end else begin
					st_nxt = refill_q ? ST_POP_RD : ST_IDLE;
				end
			end
			ST_POP_RD: begin
				if (cnt_q == '0) begin
					ev.vld   = 1'b1;
					ev.empty = 1'b1;
					st_nxt   = ST_OUT;
				end else begin
					ram_raddr_b = IW'(cnt_q - 1'b1);
					st_nxt      = ST_POP_TOP;
				end
			end
			ST_POP_TOP: begin
				ev.vld = 1'b1;
				st_nxt = (cnt_q == '0) ? ST_OUT : ST_SD_RD;
			end
			ST_SD_RD: begin
				if (l_ok) begin
					ram_raddr_a = lchild[IW-1:0];
					ram_raddr_b = lchild[IW-1:0] + 1'b1;
					st_nxt      = ST_SD_CMP;
				end else begin
					ram_we = 1'b1;
					st_nxt = ST_OUT;
				end
			end
			ST_SD_CMP: begin
				ram_we = 1'b1;
				if (child < x_q) begin
					ram_wdata = child;
					st_nxt    = ST_SD_RD;
				end else begin
					st_nxt = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					deliver = 1'b1;
					st_nxt  = ST_IDLE;
				end
			end
			default: st_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			last_run_q <= '0;
			refill_q   <= 1'b0;
		end else begin
			if (accept) begin
				refill_q <= func_t'(in_func) == FN_REFILL;
				if (ins_ok && (func_t'(in_func) == FN_LOAD || func_t'(in_func) == FN_REFILL)) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (st_q == ST_POP_RD && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (st_q == ST_POP_TOP) begin
				last_run_q <= ram_rdata_a[RUN_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= {in_key, ins_run};
			idx_q <= IW'(cnt_q);
		end
		if (st_q == ST_INS_RD) begin
			par_q <= par;
		end
		if (st_q == ST_INS_CMP && x_q < ram_rdata_a) begin
			idx_q <= par_q;
		end
		if (st_q == ST_POP_TOP) begin
			x_q   <= ram_rdata_b;
			idx_q <= '0;
		end
		if (st_q == ST_SD_RD) begin
			lc_q <= lchild;
		end
		if (st_q == ST_SD_CMP && child < x_q) begin
			idx_q <= cidx;
		end
	end

	`KMG_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= MAX_RUNS, "heap count past capacity")
	`KMG_ASSERT_IMP(a_sd_in_heap, clk, arst_n, st_q == ST_SD_CMP, LW'(idx_q) < LW'(cnt_q), "sift index outside heap")
	`KMG_ASSERT_IMP(a_ins_parent, clk, arst_n, st_q == ST_INS_CMP, idx_q != '0, "compare at root without parent")
	`KMG_ASSERT_NXT(a_pop_start, clk, arst_n, accept && func_t'(in_func) == FN_POP, st_q == ST_POP_RD, "pop transfer did not start pop")

endmodule

// ===== rtl/kmg_tally.sv =====
`timescale 1ns / 1ps
module kmg_tally
	import kmg_pkg::*;
#(
	parameter int VERTEX_BITS = VERTEX_BITS_DEF,
	parameter int LABEL_BITS  = LABEL_BITS_DEF,
	localparam int EW = 2 * VERTEX_BITS + LABEL_BITS + RUN_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pop_ev_t                ev,
	input  logic [EW-1:0]          entry,
	output logic [RUN_BITS-1:0]    res_run,
	output logic [VERTEX_BITS-1:0] res_src,
	output logic [VERTEX_BITS-1:0] res_dst,
	output logic [LABEL_BITS-1:0]  res_lab,
	output flags_t                 res_flags,
	output logic [CNT_BITS-1:0]    res_pairs,
	output logic [CNT_BITS-1:0]    res_labels
);

	logic                   open_q;
	logic [VERTEX_BITS-1:0] cur_src_q;
	logic [VERTEX_BITS-1:0] cur_dst_q;
	logic [LABEL_BITS-1:0]  prev_lab_q;
	logic [CNT_BITS-1:0]    pairs_q;
	logic [CNT_BITS-1:0]    labels_q;

	logic [RUN_BITS-1:0]    e_run;
	logic [VERTEX_BITS-1:0] e_src;
	logic [VERTEX_BITS-1:0] e_dst;
	logic [LABEL_BITS-1:0]  e_lab;
	logic                   np;
	logic                   rep;
	logic [CNT_BITS-1:0]    pairs_nxt;
	logic [CNT_BITS-1:0]    labels_nxt;
	logic                   take;

	assign {e_src, e_dst, e_lab, e_run} = entry;
	assign take = ev.vld && !ev.empty;
	assign np   = !open_q || e_src != cur_src_q || e_dst != cur_dst_q;
	assign rep  = !np && e_lab == prev_lab_q;

	always_comb begin
		pairs_nxt  = pairs_q;
		labels_nxt = labels_q;
		if (np && pairs_q != '1) begin
			pairs_nxt = pairs_q + 1'b1;
		end
		if (!rep && labels_q != '1) begin
			labels_nxt = labels_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q     <= 1'b0;
			cur_src_q  <= '0;
			cur_dst_q  <= '0;
			prev_lab_q <= '0;
			pairs_q    <= '0;
			labels_q   <= '0;
		end else if (take) begin
			open_q     <= 1'b1;
			cur_src_q  <= e_src;
			cur_dst_q  <= e_dst;
			prev_lab_q <= e_lab;
			pairs_q    <= pairs_nxt;
			labels_q   <= labels_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (ev.vld) begin
			if (ev.empty) begin
				res_run    <= '0;
				res_src    <= '0;
				res_dst    <= '0;
				res_lab    <= '0;
				res_flags  <= '{heap_empty: 1'b1, repeat_label: 1'b0, new_pair: 1'b0};
				res_pairs  <= '0;
				res_labels <= '0;
			end else begin
				res_run    <= e_run;
				res_src    <= e_src;
				res_dst    <= e_dst;
				res_lab    <= e_lab;
				res_flags  <= '{heap_empty: 1'b0, repeat_label: rep, new_pair: np};
				res_pairs  <= pairs_nxt;
				res_labels <= labels_nxt;
			end
		end
	end

endmodule

// ===== rtl/kway_merge_group_edges_unit.sv =====
`timescale 1ns / 1ps
// channel  dir  tdata (low bit first)                              tuser
// s_*      in   run, src_vertex, dst_vertex, edge_label            func
// m_*      out  out_run, out_src, out_dst, out_label,              new_pair, repeat_label,
//               pairs_seen, labels_seen                            heap_empty
//
// One item at a time; s_tready is high only while the sequencer waits for work.
// Load: the new record is written at the root or, per level, compared with its parent, which
// moves down while larger; a full heap drops it. Pop: an empty heap gives heap_empty, else the
// top goes out and the last record sifts down from the root; a refill is a load then a pop.
// Each level is a heap memory read then a compare-write. Reset clears the heap count and
// pair tracking, no clearing pass. m_* holds a result until taken; a pop waits while held.
module kway_merge_group_edges_unit
	import kmg_pkg::*;
#(
	parameter int MAX_RUNS    = MAX_RUNS_DEF,
	parameter int VERTEX_BITS = VERTEX_BITS_DEF,
	parameter int LABEL_BITS  = LABEL_BITS_DEF,
	localparam int IN_W   = RUN_BITS + 2 * VERTEX_BITS + LABEL_BITS,
	localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
	localparam int OUT_W  = IN_W + 2 * CNT_BITS,
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_TW-1:0]  s_tdata,  // run, src_vertex, dst_vertex, edge_label
	input  logic [1:0]        s_tuser,  // func
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_TW-1:0] m_tdata,  // out_run, out_src, out_dst, out_label, pairs_seen, labels_seen
	output logic [2:0]        m_tuser   // new_pair, repeat_label, heap_empty
);

	localparam int EW = 2 * VERTEX_BITS + LABEL_BITS + RUN_BITS;
	localparam int IW = $clog2(MAX_RUNS);

	logic                   m_tvalid_q;
	logic [OUT_TW-1:0]      m_tdata_q;
	logic [2:0]             m_tuser_q;

	logic                   out_free;
	logic                   deliver;
	pop_ev_t                ev;
	logic                   ram_we;
	logic [IW-1:0]          ram_waddr;
	logic [EW-1:0]          ram_wdata;
	logic [IW-1:0]          ram_raddr_a;
	logic [IW-1:0]          ram_raddr_b;
	logic [EW-1:0]          ram_rdata_a;
	logic [EW-1:0]          ram_rdata_b;

	logic [RUN_BITS-1:0]    res_run;
	logic [VERTEX_BITS-1:0] res_src;
	logic [VERTEX_BITS-1:0] res_dst;
	logic [LABEL_BITS-1:0]  res_lab;
	flags_t                 res_flags;
	logic [CNT_BITS-1:0]    res_pairs;
	logic [CNT_BITS-1:0]    res_labels;

	logic [RUN_BITS-1:0]    in_run;
	logic [EW-RUN_BITS-1:0] in_key;

	assign in_run = s_tdata[RUN_BITS-1:0];
	assign in_key = {s_tdata[RUN_BITS +: VERTEX_BITS],
		s_tdata[RUN_BITS + VERTEX_BITS +: VERTEX_BITS],
		s_tdata[RUN_BITS + 2 * VERTEX_BITS +: LABEL_BITS]};

	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	kmg_heap_ram #(
		.DEPTH (MAX_RUNS),
		.WIDTH (EW)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

	kmg_seq #(
		.MAX_RUNS    (MAX_RUNS),
		.VERTEX_BITS (VERTEX_BITS),
		.LABEL_BITS  (LABEL_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_vld      (s_tvalid),
		.in_rdy      (s_tready),
		.in_func     (s_tuser),
		.in_run      (in_run),
		.in_key      (in_key),
		.out_free    (out_free),
		.deliver     (deliver),
		.ev          (ev),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_raddr_a (ram_raddr_a),
		.ram_raddr_b (ram_raddr_b),
		.ram_rdata_a (ram_rdata_a),
		.ram_rdata_b (ram_rdata_b)
	);

	kmg_tally #(
		.VERTEX_BITS (VERTEX_BITS),
		.LABEL_BITS  (LABEL_BITS)
	) u_tally (
		.clk        (clk),
		.arst_n     (arst_n),
		.ev         (ev),
		.entry      (ram_rdata_a),
		.res_run    (res_run),
		.res_src    (res_src),
		.res_dst    (res_dst),
		.res_lab    (res_lab),
		.res_flags  (res_flags),
		.res_pairs  (res_pairs),
		.res_labels (res_labels)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (deliver) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (deliver) begin
			m_tdata_q <= OUT_TW'({res_labels, res_pairs, res_lab, res_dst, res_src, res_run});
			m_tuser_q <= res_flags;
		end
	end

endmodule

// ===== tb/sv/kway_merge_group_edges_unit_checker.sv =====
`timescale 1ns / 1ps
module kway_merge_group_edges_unit_checker
	import kmg_pkg::*;
#(
	localparam int IN_W   = RUN_BITS + 2 * VERTEX_BITS_DEF + LABEL_BITS_DEF,
	localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
	localparam int OUT_W  = IN_W + 2 * CNT_BITS,
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [IN_TW-1:0]  s_tdata,
	input  logic [1:0]        s_tuser,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [OUT_TW-1:0] m_tdata,
	input  logic [2:0]        m_tuser,
	output int                err_count,
	output int                pending
);

	typedef struct packed {
		logic [IN_TW-IN_W-1:0]     pad;
		logic [LABEL_BITS_DEF-1:0]  lab;
		logic [VERTEX_BITS_DEF-1:0] dst;
		logic [VERTEX_BITS_DEF-1:0] src;
		logic [RUN_BITS-1:0]        run;
	} edge_beat_t;

	typedef struct packed {
		logic [OUT_TW-OUT_W-1:0]    pad;
		logic [CNT_BITS-1:0]        labels;
		logic [CNT_BITS-1:0]        pairs;
		logic [LABEL_BITS_DEF-1:0]  lab;
		logic [VERTEX_BITS_DEF-1:0] dst;
		logic [VERTEX_BITS_DEF-1:0] src;
		logic [RUN_BITS-1:0]        run;
	} merged_beat_t;

	typedef struct {
		merged_beat_t data;
		flags_t       flags;
	} merged_edge_t;

	edge_beat_t                 run_heads[MAX_RUNS_DEF];
	int                         head_count = 0;
	logic [RUN_BITS-1:0]        last_run = '0;
	bit                         pair_open = 1'b0;
	logic [VERTEX_BITS_DEF-1:0] cur_src = '0;
	logic [VERTEX_BITS_DEF-1:0] cur_dst = '0;
	logic [LABEL_BITS_DEF-1:0]  prev_label = '0;
	logic [CNT_BITS-1:0]        pair_total = '0;
	logic [CNT_BITS-1:0]        label_total = '0;
	merged_edge_t               merged_edges[$];

	initial begin
		err_count = 0;
		pending = 0;
	end

	function automatic logic [IN_W-1:0] merge_order(edge_beat_t e);
		return {e.src, e.dst, e.lab, e.run};
	endfunction

	function automatic void store_head(edge_beat_t e);
		if (head_count < MAX_RUNS_DEF) begin
			run_heads[head_count] = e;
			head_count++;
		end
	endfunction

	function automatic merged_edge_t pop_min_edge();
		merged_edge_t res;
		edge_beat_t   e;
		int           best;
		res.data = '0;
		res.flags = '0;
		if (head_count == 0) begin
			res.flags.heap_empty = 1'b1;
			return res;
		end
		best = 0;
		for (int i = 1; i < head_count; i++)
			if (merge_order(run_heads[i]) < merge_order(run_heads[best]))
				best = i;
		e = run_heads[best];
		head_count--;
		run_heads[best] = run_heads[head_count];
		last_run = e.run;
		if (!pair_open || e.src != cur_src || e.dst != cur_dst) begin
			cur_src = e.src;
			cur_dst = e.dst;
			prev_label = e.lab;
			pair_open = 1'b1;
			if (pair_total != '1)
				pair_total++;
			if (label_total != '1)
				label_total++;
			res.flags.new_pair = 1'b1;
		end else if (e.lab != prev_label) begin
			prev_label = e.lab;
			if (label_total != '1)
				label_total++;
		end else begin
			res.flags.repeat_label = 1'b1;
		end
		res.data.run = e.run;
		res.data.src = e.src;
		res.data.dst = e.dst;
		res.data.lab = e.lab;
		res.data.pairs = pair_total;
		res.data.labels = label_total;
		return res;
	endfunction

	task automatic check_field(string name, logic [CNT_BITS-1:0] want, logic [CNT_BITS-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk) begin
		edge_beat_t   beat;
		merged_beat_t got;
		flags_t       got_flags;
		merged_edge_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				beat = s_tdata;
				case (s_tuser)
					FN_LOAD: store_head(beat);
					FN_REFILL: begin
						beat.run = last_run;
						store_head(beat);
						merged_edges.insert(merged_edges.size(), pop_min_edge());
					end
					FN_POP: merged_edges.insert(merged_edges.size(), pop_min_edge());
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				got_flags = m_tuser;
				if (merged_edges.size() == 0) begin
					$error("unexpected merged edge transfer: 0x%0h user 0x%0h", m_tdata, m_tuser);
					err_count++;
				end else begin
					want = merged_edges.pop_front();
					check_field("out_run", CNT_BITS'(want.data.run), CNT_BITS'(got.run));
					check_field("out_src", CNT_BITS'(want.data.src), CNT_BITS'(got.src));
					check_field("out_dst", CNT_BITS'(want.data.dst), CNT_BITS'(got.dst));
					check_field("out_label", CNT_BITS'(want.data.lab), CNT_BITS'(got.lab));
					check_field("pairs_seen", want.data.pairs, got.pairs);
					check_field("labels_seen", want.data.labels, got.labels);
					check_field("tdata_pad", CNT_BITS'(want.data.pad), CNT_BITS'(got.pad));
					check_field("new_pair", CNT_BITS'(want.flags.new_pair),
						CNT_BITS'(got_flags.new_pair));
					check_field("repeat_label", CNT_BITS'(want.flags.repeat_label),
						CNT_BITS'(got_flags.repeat_label));
					check_field("heap_empty", CNT_BITS'(want.flags.heap_empty),
						CNT_BITS'(got_flags.heap_empty));
				end
			end
			pending = merged_edges.size();
		end
	end

endmodule

// ===== tb/sv/kway_merge_group_edges_unit_tb.sv =====
`timescale 1ns / 1ps
module kway_merge_group_edges_unit_tb;
	import kmg_pkg::*;

	localparam int IN_W        = RUN_BITS + 2 * VERTEX_BITS_DEF + LABEL_BITS_DEF;
	localparam int IN_TW       = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W       = IN_W + 2 * CNT_BITS;
	localparam int OUT_TW      = ((OUT_W + 7) / 8) * 8;
	localparam int ITEM_TARGET = 1750;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 40;
	localparam logic [1:0] FN_UNUSED = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_TW-1:0]  s_tdata = '0;
	logic [1:0]        s_tuser = FN_LOAD;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_TW-1:0] m_tdata;
	logic [2:0]        m_tuser;
	int                err_count;
	int                pending;

	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	bit hold_req = 1'b0;
	int items_sent = 0;
	int heap_fill = 0;
	int stall_cycles = 0;

	always #10 clk = ~clk;

	kway_merge_group_edges_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	kway_merge_group_edges_unit_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.err_count (err_count),
		.pending   (pending)
	);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("kway_merge_group_edges_unit_tb NOT OK");
			$finish;
		end
	end

	initial begin
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			m_tready <= !(rx_idle_on && $urandom_range(99) < 8);
			@(posedge clk);
		end
	end

	task automatic send_edge(input logic [1:0] fn, input logic [RUN_BITS-1:0] run,
			input logic [VERTEX_BITS_DEF-1:0] src, input logic [VERTEX_BITS_DEF-1:0] dst,
			input logic [LABEL_BITS_DEF-1:0] lab);
		while (tx_idle_on && $urandom_range(99) < 8) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= {{(IN_TW-IN_W){1'b0}}, lab, dst, src, run};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
		case (fn)
			FN_LOAD: if (heap_fill < MAX_RUNS_DEF) heap_fill++;
			FN_REFILL: if (heap_fill == MAX_RUNS_DEF) heap_fill--;
			FN_POP: if (heap_fill > 0) heap_fill--;
			default: ;
		endcase
	endtask

	// mostly a few small or near-max values so pairs and labels collide
	task automatic send_random_edge(input logic [1:0] fn, input logic [RUN_BITS-1:0] run);
		logic [VERTEX_BITS_DEF-1:0] src, dst;
		logic [LABEL_BITS_DEF-1:0]  lab;
		case ($urandom_range(3))
			0, 1: begin
				src = VERTEX_BITS_DEF'($urandom_range(3));
				dst = VERTEX_BITS_DEF'($urandom_range(3));
				lab = LABEL_BITS_DEF'($urandom_range(3));
			end
			2: begin
				src = '1 - VERTEX_BITS_DEF'($urandom_range(2));
				dst = '1 - VERTEX_BITS_DEF'($urandom_range(2));
				lab = '1 - LABEL_BITS_DEF'($urandom_range(2));
			end
			default: begin
				src = VERTEX_BITS_DEF'($urandom);
				dst = VERTEX_BITS_DEF'($urandom);
				lab = LABEL_BITS_DEF'($urandom);
			end
		endcase
		send_edge(fn, run, src, dst, lab);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic merge_session(input int heads);
		int pick;
		for (int i = 0; i < heads; i++)
			send_random_edge(FN_LOAD,
				$urandom_range(1) ? i[RUN_BITS-1:0] : RUN_BITS'($urandom_range(63)));
		while (heap_fill > 0 && items_sent < ITEM_TARGET) begin
			pick = $urandom_range(99);
			if (pick < 60)
				send_random_edge(FN_REFILL, RUN_BITS'($urandom_range(63)));
			else if (pick < 92)
				send_random_edge(FN_POP, RUN_BITS'($urandom_range(63)));
			else if (pick < 96)
				send_edge(FN_UNUSED, RUN_BITS'($urandom_range(63)), VERTEX_BITS_DEF'($urandom),
					VERTEX_BITS_DEF'($urandom), LABEL_BITS_DEF'($urandom));
			else
				send_random_edge(FN_LOAD, RUN_BITS'($urandom_range(63)));
		end
		if (heap_fill == 0 && $urandom_range(3) == 0)
			send_random_edge(FN_POP, RUN_BITS'($urandom_range(63)));
	endtask

	initial begin
		int  heads;
		int  sessions;
		bit  hold_done;
		sessions = 0;
		hold_done = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_edge(FN_POP, '0, '0, '0, '0);
		send_edge(FN_REFILL, '1, 24'd5, 24'd6, 16'd7);
		send_edge(FN_UNUSED, '1, '1, '1, '1);
		send_edge(FN_LOAD, 6'd63, '1, '1, '1);
		send_edge(FN_LOAD, 6'd0, '0, '0, '0);
		send_edge(FN_LOAD, 6'd42, 24'hAAAAAA, 24'h555555, 16'hA5A5);
		send_edge(FN_LOAD, 6'd5, 24'd7, 24'd7, 16'd7);
		send_edge(FN_LOAD, 6'd3, 24'd7, 24'd7, 16'd7);
		send_edge(FN_LOAD, 6'd9, 24'd7, 24'd7, 16'd2);
		repeat (4) send_edge(FN_POP, '0, '0, '0, '0);
		send_edge(FN_REFILL, '0, 24'd7, 24'd7, 16'd8);
		send_edge(FN_REFILL, '0, 24'd7, 24'd8, 16'd8);
		repeat (3) send_edge(FN_POP, '1, '1, '1, '1);
		send_edge(FN_LOAD, 6'd21, 24'h555555, 24'hAAAAAA, 16'h5A5A);
		send_edge(FN_POP, '0, '0, '0, '0);
		drain_results();

		while (items_sent < ITEM_TARGET) begin
			tx_idle_on = !(items_sent >= 700 && items_sent < 1000);
			rx_idle_on = tx_idle_on;
			if (!hold_done && items_sent >= 400) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			if (sessions == 0)
				heads = 66;
			else if ($urandom_range(11) == 0)
				heads = $urandom_range(70, 60);
			else
				heads = $urandom_range(12, 1);
			merge_session(heads);
			sessions++;
			if ($urandom_range(3) == 0)
				drain_results();
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("kway_merge_group_edges_unit_tb OK");
		else
			$display("kway_merge_group_edges_unit_tb NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/kmg_pkg.sv
rtl/kmg_heap_ram.sv
rtl/kmg_seq.sv
rtl/kmg_tally.sv
rtl/kway_merge_group_edges_unit.sv
tb/sv/kway_merge_group_edges_unit_checker.sv
tb/sv/kway_merge_group_edges_unit_tb.sv
